>>> sv/oas_pkg.sv
package oas_pkg;

  // Default sizes of the block.
  localparam int MAX_DIM_DEF   = 16;
  localparam int COST_BITS_DEF = 24;
  localparam int WORK_BITS_DEF = 48;

  // Fixed field widths of the ports.
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int IDX_W     = 4;
  localparam int TOTAL_W   = 28;

  // Scale applied to the largest finite cost times the element count to stand in for infinity.
  localparam int INF_SCALE = 10;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS = 1'b0,
    CFG_NUM_COLS = 1'b1
  } cfg_reg_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Compare results of the shared arithmetic unit.
  typedef struct packed {
    logic lt;
    logic eq;
  } alu_flags_t;

endpackage

>>> sv/oas_ram.sv
module oas_ram #(
  parameter int W     = 48,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/oas_alu.sv
module oas_alu #(
  parameter int W = 48
) (
  input  oas_pkg::alu_op_t    op,
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  output logic [W-1:0]        y,
  output oas_pkg::alu_flags_t flags
);

  // Shared add/subtract with magnitude compare.
  always_comb begin
    case (op)
      oas_pkg::ALU_ADD: y = a + b;
      oas_pkg::ALU_SUB: y = a - b;
      default:          y = a - b;
    endcase
    flags.lt = (a < b);
    flags.eq = (a == b);
  end

endmodule

>>> sv/optimal_assignment_solver_core.sv
// Optimal assignment solver (Hungarian method) for a rows x cols cost matrix.
// Configuration: cfg_index 0 sets the row count, 1 the column count (1..MAX_DIM,
// 0 reads as 1, larger values as MAX_DIM); a write restarts the matrix load.
// Input channel: one cost per transaction in column-major order, with an
// infinity flag. During the load one transaction is taken per cycle.
// After the last element the block drops in_ready and solves: the working
// costs live in one memory with a single read and a single write port, and
// each element visit first reads, then compares/updates through the one
// shared adder. The reductions are followed by prime and minimum passes
// over the matrix; the number of passes grows with the dimension.
// Result channel: one transaction per row, row 0 first, each carrying the
// assigned column, a valid flag and the total finite cost; last_row marks
// the final row. A stalled receiver holds the current result; in_ready
// returns the cycle after the last result is taken.
// Reset: synchronous, active low; both dimensions return to MAX_DIM and any
// partial load is dropped.
module optimal_assignment_solver_core #(
  parameter int MAX_DIM   = oas_pkg::MAX_DIM_DEF,
  parameter int COST_BITS = oas_pkg::COST_BITS_DEF,
  parameter int WORK_BITS = oas_pkg::WORK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COST_BITS-1:0]          in_cost_value,
  input  logic                          in_cost_infinite,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [oas_pkg::IDX_W-1:0]     out_row_index,
  output logic [oas_pkg::IDX_W-1:0]     out_assigned_col,
  output logic                          out_assigned_valid,
  output logic [oas_pkg::TOTAL_W-1:0]   out_total_cost,
  output logic                          out_last_row,
  input  logic                          cfg_we,
  input  logic [oas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [oas_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int RW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int AW    = 2 * RW;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int OW    = COST_BITS + 1;
  localparam int NW    = 2 * DW;
  localparam int PW    = COST_BITS + NW;
  localparam int TW    = (PW + 4 > WORK_BITS) ? PW + 4 : WORK_BITS;
  localparam int IW    = oas_pkg::IDX_W;
  localparam int TOTW  = oas_pkg::TOTAL_W;
  localparam int CW    = oas_pkg::CFG_W;

  typedef enum logic [15:0] {
    S_LOAD  = 16'h0001,
    S_INF0  = 16'h0002,
    S_INF1  = 16'h0004,
    S_INF2  = 16'h0008,
    S_INIT  = 16'h0010,
    S_RMIN  = 16'h0020,
    S_RSUB  = 16'h0040,
    S_COVER = 16'h0080,
    S_PRIME = 16'h0100,
    S_AUG0  = 16'h0200,
    S_AUGF  = 16'h0400,
    S_AUGE  = 16'h0800,
    S_AMIN  = 16'h1000,
    S_AADJ  = 16'h2000,
    S_RES   = 16'h4000,
    S_OUT   = 16'h8000
  } state_t;

  function automatic logic [DW-1:0] clamp_dim(input logic [CW-1:0] v);
    logic [DW-1:0] d;
    if (v == '0) begin
      d = DW'(1);
    end else if (32'(v) > MAX_DIM) begin
      d = DW'(MAX_DIM);
    end else begin
      d = DW'(v);
    end
    return d;
  endfunction

  function automatic logic [DW-1:0] count_ones(input logic [MAX_DIM-1:0] v);
    logic [DW-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      n = n + DW'(v[i]);
    end
    return n;
  endfunction

  // Control registers.
  state_t                state_r, state_nxt;
  logic                  ph_r, ph_nxt;
  logic [RW-1:0]         a_r, a_nxt, b_r, b_nxt;
  logic [RW-1:0]         ld_r_r, ld_r_nxt, ld_c_r, ld_c_nxt;
  logic [DW-1:0]         rows_r, rows_nxt, cols_r, cols_nxt;
  logic                  finite_r, finite_nxt, anyinf_r, anyinf_nxt;
  logic                  tr_r, tr_nxt;
  logic                  found_r, found_nxt, have_r, have_nxt, done_r, done_nxt;
  logic [MAX_DIM-1:0]    star_v_r, star_v_nxt, prime_v_r, prime_v_nxt;
  logic [MAX_DIM-1:0]    row_cov_r, row_cov_nxt, col_cov_r, col_cov_nxt;
  logic [MAX_DIM-1:0]    asg_v_r, asg_v_nxt, old_v_r, old_v_nxt;

  // Payload registers.
  logic [RW-1:0]         star_col_r [MAX_DIM];
  logic [RW-1:0]         star_col_nxt [MAX_DIM];
  logic [RW-1:0]         prime_col_r [MAX_DIM];
  logic [RW-1:0]         prime_col_nxt [MAX_DIM];
  logic [RW-1:0]         old_col_r [MAX_DIM];
  logic [RW-1:0]         old_col_nxt [MAX_DIM];
  logic [COST_BITS-1:0]  max_r, max_nxt;
  logic [WORK_BITS-1:0]  min_r, min_nxt;
  logic [RW-1:0]         sc_r, sc_nxt, pr_r, pr_nxt, pc_r, pc_nxt;
  logic [NW-1:0]         nprod_r, nprod_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic [WORK_BITS-1:0]  infv_r, infv_nxt;
  logic [TOTW-1:0]       total_r, total_nxt;

  // Memory and arithmetic unit connections.
  logic                  wm_we, om_we;
  logic [AW-1:0]         wm_waddr, wm_raddr, om_waddr, om_raddr;
  logic [WORK_BITS-1:0]  wm_wdata, wm_q;
  logic [OW-1:0]         om_wdata, om_q;
  oas_pkg::alu_op_t      alu_op;
  logic [WORK_BITS-1:0]  alu_a, alu_b, alu_y;
  oas_pkg::alu_flags_t   alu_f;

  // Scan helpers.
  logic                  o_sel, a_end, b_end, scan_done, last_load;
  logic [RW-1:0]         rows_m1, cols_m1, row_sel, col_sel;
  logic [RW-1:0]         step_a, step_b, nc_a;
  logic [AW-1:0]         scan_addr;
  logic [DW-1:0]         dim;
  logic [MAX_DIM-1:0]    star_cols, cov_all;
  logic                  find_hit, col_adv, col_fnd;
  logic [RW-1:0]         find_row;
  logic [TW-1:0]         inf_scaled;

  oas_ram #(.W(WORK_BITS), .DEPTH(DEPTH), .AW(AW)) u_work_ram (
    .clk   (clk),
    .we    (wm_we),
    .waddr (wm_waddr),
    .wdata (wm_wdata),
    .raddr (wm_raddr),
    .rdata (wm_q)
  );

  oas_ram #(.W(OW), .DEPTH(DEPTH), .AW(AW)) u_orig_ram (
    .clk   (clk),
    .we    (om_we),
    .waddr (om_waddr),
    .wdata (om_wdata),
    .raddr (om_raddr),
    .rdata (om_q)
  );

  oas_alu #(.W(WORK_BITS)) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .y     (alu_y),
    .flags (alu_f)
  );

  // Scan orientation: the reductions walk rows or columns as the shape asks.
  assign o_sel     = ((state_r == S_RMIN) || (state_r == S_RSUB)) ? tr_r : 1'b1;
  assign rows_m1   = RW'(rows_r - 1'b1);
  assign cols_m1   = RW'(cols_r - 1'b1);
  assign row_sel   = o_sel ? b_r : a_r;
  assign col_sel   = o_sel ? a_r : b_r;
  assign b_end     = (b_r == (o_sel ? rows_m1 : cols_m1));
  assign a_end     = (a_r == (o_sel ? cols_m1 : rows_m1));
  assign scan_done = a_end && b_end;
  assign step_b    = b_end ? '0 : b_r + 1'b1;
  assign step_a    = b_end ? (a_end ? '0 : a_r + 1'b1) : a_r;
  assign nc_a      = a_end ? '0 : a_r + 1'b1;
  assign scan_addr = {col_sel, row_sel};
  assign dim       = tr_r ? cols_r : rows_r;
  assign last_load = (ld_r_r == rows_m1) && (ld_c_r == cols_m1);
  assign inf_scaled = TW'(prod_r) * TW'(oas_pkg::INF_SCALE);
  assign cov_all   = col_cov_r | star_cols;

  // Columns that hold a star.
  always_comb begin
    star_cols = '0;
    for (int r = 0; r < MAX_DIM; r++) begin
      if (star_v_r[r]) begin
        star_cols[star_col_r[r]] = 1'b1;
      end
    end
  end

  // Row whose previous star sits in the current path column.
  always_comb begin
    find_hit = 1'b0;
    find_row = '0;
    for (int r = MAX_DIM - 1; r >= 0; r--) begin
      if (old_v_r[r] && (old_col_r[r] == sc_r)) begin
        find_hit = 1'b1;
        find_row = RW'(r);
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ld_r_nxt      = ld_r_r;
    ld_c_nxt      = ld_c_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    finite_nxt    = finite_r;
    anyinf_nxt    = anyinf_r;
    tr_nxt        = tr_r;
    found_nxt     = found_r;
    have_nxt      = have_r;
    done_nxt      = done_r;
    star_v_nxt    = star_v_r;
    prime_v_nxt   = prime_v_r;
    row_cov_nxt   = row_cov_r;
    col_cov_nxt   = col_cov_r;
    asg_v_nxt     = asg_v_r;
    old_v_nxt     = old_v_r;
    star_col_nxt  = star_col_r;
    prime_col_nxt = prime_col_r;
    old_col_nxt   = old_col_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    sc_nxt        = sc_r;
    pr_nxt        = pr_r;
    pc_nxt        = pc_r;
    nprod_nxt     = nprod_r;
    prod_nxt      = prod_r;
    infv_nxt      = infv_r;
    total_nxt     = total_r;

    wm_we    = 1'b0;
    wm_waddr = scan_addr;
    wm_wdata = alu_y;
    wm_raddr = scan_addr;
    om_we    = 1'b0;
    om_waddr = {ld_c_r, ld_r_r};
    om_wdata = {in_cost_infinite, in_cost_value};
    om_raddr = scan_addr;
    alu_op   = oas_pkg::ALU_SUB;
    alu_a    = wm_q;
    alu_b    = min_r;
    col_adv  = 1'b0;
    col_fnd  = found_r;

    case (state_r)
      // Store the matrix, one element per transaction.
      S_LOAD: begin
        if (in_valid) begin
          om_we = 1'b1;
          if (in_cost_infinite) begin
            anyinf_nxt = 1'b1;
          end else if (!finite_r || (in_cost_value > max_r)) begin
            max_nxt    = in_cost_value;
            finite_nxt = 1'b1;
          end
          if (last_load) begin
            ld_r_nxt    = '0;
            ld_c_nxt    = '0;
            star_v_nxt  = '0;
            prime_v_nxt = '0;
            row_cov_nxt = '0;
            col_cov_nxt = '0;
            asg_v_nxt   = '0;
            total_nxt   = '0;
            tr_nxt      = (rows_r > cols_r);
            a_nxt       = '0;
            b_nxt       = '0;
            ph_nxt      = 1'b0;
            // With every entry infinite, nothing is solved.
            state_nxt   = finite_nxt ? S_INF0 : S_OUT;
          end else if (ld_r_r == rows_m1) begin
            ld_r_nxt = '0;
            ld_c_nxt = ld_c_r + 1'b1;
          end else begin
            ld_r_nxt = ld_r_r + 1'b1;
          end
        end
      end
      // Value that stands in for an infinite entry.
      S_INF0: begin
        nprod_nxt = NW'(rows_r) * NW'(cols_r);
        state_nxt = S_INF1;
      end
      S_INF1: begin
        prod_nxt  = PW'(max_r) * PW'(nprod_r);
        state_nxt = S_INF2;
      end
      S_INF2: begin
        infv_nxt  = (max_r == '0) ? WORK_BITS'(oas_pkg::INF_SCALE)
                                  : inf_scaled[WORK_BITS-1:0];
        state_nxt = S_INIT;
      end
      // Copy the original costs into the working store.
      S_INIT: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          wm_we    = 1'b1;
          wm_wdata = om_q[COST_BITS] ? infv_r : WORK_BITS'(om_q[COST_BITS-1:0]);
          a_nxt    = step_a;
          b_nxt    = step_b;
          ph_nxt   = 1'b0;
          if (scan_done) begin
            state_nxt = S_RMIN;
          end
        end
      end
      // Minimum of one row (or column).
      S_RMIN: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if ((b_r == '0) || alu_f.lt) begin
            min_nxt = wm_q;
          end
          if (b_end) begin
            b_nxt     = '0;
            done_nxt  = 1'b0;
            state_nxt = S_RSUB;
          end else begin
            b_nxt = b_r + 1'b1;
          end
        end
      end
      // Subtract the minimum and star the first free zero.
      S_RSUB: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          wm_we  = 1'b1;
          if (!tr_r) begin
            if (alu_f.eq && !col_cov_r[b_r] && !done_r) begin
              star_v_nxt[a_r]   = 1'b1;
              star_col_nxt[a_r] = b_r;
              col_cov_nxt[b_r]  = 1'b1;
              done_nxt          = 1'b1;
            end
          end else begin
            if (alu_f.eq && !row_cov_r[b_r] && !done_r) begin
              star_v_nxt[b_r]   = 1'b1;
              star_col_nxt[b_r] = a_r;
              col_cov_nxt[a_r]  = 1'b1;
              row_cov_nxt[b_r]  = 1'b1;
              done_nxt          = 1'b1;
            end
          end
          a_nxt = step_a;
          b_nxt = step_b;
          if (b_end) begin
            if (a_end) begin
              row_cov_nxt = '0;
              state_nxt   = S_COVER;
            end else begin
              state_nxt = S_RMIN;
            end
          end
        end
      end
      // Cover starred columns and test for a full assignment.
      S_COVER: begin
        col_cov_nxt = cov_all;
        a_nxt       = '0;
        b_nxt       = '0;
        ph_nxt      = 1'b0;
        found_nxt   = 1'b0;
        if (count_ones(cov_all) == dim) begin
          state_nxt = S_RES;
        end else begin
          state_nxt = S_PRIME;
        end
      end
      // Prime uncovered zeros, column by column.
      S_PRIME: begin
        alu_b = '0;
        if (!ph_r) begin
          if (col_cov_r[a_r]) begin
            col_adv = 1'b1;
          end else if (row_cov_r[b_r]) begin
            if (b_end) begin
              col_adv = 1'b1;
            end else begin
              b_nxt = b_r + 1'b1;
            end
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          ph_nxt = 1'b0;
          if (alu_f.eq) begin
            prime_v_nxt[b_r]   = 1'b1;
            prime_col_nxt[b_r] = a_r;
            if (!star_v_r[b_r]) begin
              pr_nxt    = b_r;
              pc_nxt    = a_r;
              state_nxt = S_AUG0;
            end else begin
              row_cov_nxt[b_r]             = 1'b1;
              col_cov_nxt[star_col_r[b_r]] = 1'b0;
              found_nxt                    = 1'b1;
              col_fnd                      = 1'b1;
              col_adv                      = 1'b1;
            end
          end else if (b_end) begin
            col_adv = 1'b1;
          end else begin
            b_nxt = b_r + 1'b1;
          end
        end
      end
      // Augmenting path: start with the unmatched prime.
      S_AUG0: begin
        old_v_nxt         = star_v_r;
        old_col_nxt       = star_col_r;
        star_v_nxt[pr_r]  = 1'b1;
        star_col_nxt[pr_r] = pc_r;
        sc_nxt            = pc_r;
        state_nxt         = S_AUGF;
      end
      // Swap the star in the path column for the prime in its row.
      S_AUGF: begin
        if (!find_hit) begin
          state_nxt = S_AUGE;
        end else begin
          if (star_v_r[find_row] && (star_col_r[find_row] == sc_r)) begin
            star_v_nxt[find_row] = 1'b0;
          end
          if (prime_v_r[find_row]) begin
            star_v_nxt[find_row]   = 1'b1;
            star_col_nxt[find_row] = prime_col_r[find_row];
            sc_nxt                 = prime_col_r[find_row];
          end else begin
            state_nxt = S_AUGE;
          end
        end
      end
      S_AUGE: begin
        prime_v_nxt = '0;
        row_cov_nxt = '0;
        state_nxt   = S_COVER;
      end
      // Smallest uncovered working cost.
      S_AMIN: begin
        if (!ph_r && (col_cov_r[a_r] || row_cov_r[b_r])) begin
          a_nxt = step_a;
          b_nxt = step_b;
        end else if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (!have_r || alu_f.lt) begin
            min_nxt  = wm_q;
            have_nxt = 1'b1;
          end
          a_nxt = step_a;
          b_nxt = step_b;
        end
        if ((!ph_r && (col_cov_r[a_r] || row_cov_r[b_r]) || ph_r) && scan_done) begin
          // Nothing uncovered leaves the stars as they are.
          state_nxt = have_nxt ? S_AADJ : S_RES;
        end
      end
      // Add to doubly covered entries, subtract from uncovered ones.
      S_AADJ: begin
        alu_op = row_cov_r[b_r] ? oas_pkg::ALU_ADD : oas_pkg::ALU_SUB;
        if (!ph_r && (row_cov_r[b_r] != col_cov_r[a_r])) begin
          a_nxt = step_a;
          b_nxt = step_b;
          if (scan_done) begin
            found_nxt = 1'b0;
            state_nxt = S_PRIME;
          end
        end else if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          wm_we  = 1'b1;
          a_nxt  = step_a;
          b_nxt  = step_b;
          if (scan_done) begin
            found_nxt = 1'b0;
            state_nxt = S_PRIME;
          end
        end
      end
      // Check each starred pairing against its original cost.
      S_RES: begin
        om_raddr = {star_col_r[b_r], b_r};
        alu_op   = oas_pkg::ALU_ADD;
        alu_a    = WORK_BITS'(total_r);
        alu_b    = WORK_BITS'(om_q[COST_BITS-1:0]);
        if (!ph_r && !star_v_r[b_r]) begin
          asg_v_nxt[b_r] = 1'b0;
          b_nxt          = step_b;
          if (b_end) begin
            state_nxt = S_OUT;
          end
        end else if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (om_q[COST_BITS]) begin
            asg_v_nxt[b_r] = 1'b0;
          end else begin
            asg_v_nxt[b_r] = 1'b1;
            total_nxt      = alu_y[TOTW-1:0];
          end
          b_nxt = step_b;
          if (b_end) begin
            state_nxt = S_OUT;
          end
        end
      end
      // One result transaction per row.
      S_OUT: begin
        if (out_ready) begin
          if (b_r == rows_m1) begin
            b_nxt      = '0;
            finite_nxt = 1'b0;
            anyinf_nxt = 1'b0;
            state_nxt  = S_LOAD;
          end else begin
            b_nxt = b_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // Leave the current prime-scan column.
    if (col_adv) begin
      b_nxt = '0;
      a_nxt = nc_a;
      if (a_end) begin
        if (col_fnd) begin
          found_nxt = 1'b0;
        end else begin
          have_nxt  = 1'b0;
          state_nxt = S_AMIN;
        end
      end
    end

    // Configuration write restarts the load.
    if (cfg_we) begin
      case (oas_pkg::cfg_reg_t'(cfg_index))
        oas_pkg::CFG_NUM_ROWS: rows_nxt = clamp_dim(cfg_wdata);
        oas_pkg::CFG_NUM_COLS: cols_nxt = clamp_dim(cfg_wdata);
        default: ;
      endcase
      ld_r_nxt   = '0;
      ld_c_nxt   = '0;
      finite_nxt = 1'b0;
      anyinf_nxt = 1'b0;
      a_nxt      = '0;
      b_nxt      = '0;
      ph_nxt     = 1'b0;
      state_nxt  = S_LOAD;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      ph_r      <= 1'b0;
      a_r       <= '0;
      b_r       <= '0;
      ld_r_r    <= '0;
      ld_c_r    <= '0;
      rows_r    <= DW'(MAX_DIM);
      cols_r    <= DW'(MAX_DIM);
      finite_r  <= 1'b0;
      anyinf_r  <= 1'b0;
      tr_r      <= 1'b0;
      found_r   <= 1'b0;
      have_r    <= 1'b0;
      done_r    <= 1'b0;
      star_v_r  <= '0;
      prime_v_r <= '0;
      row_cov_r <= '0;
      col_cov_r <= '0;
      asg_v_r   <= '0;
      old_v_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      ph_r      <= ph_nxt;
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      ld_r_r    <= ld_r_nxt;
      ld_c_r    <= ld_c_nxt;
      rows_r    <= rows_nxt;
      cols_r    <= cols_nxt;
      finite_r  <= finite_nxt;
      anyinf_r  <= anyinf_nxt;
      tr_r      <= tr_nxt;
      found_r   <= found_nxt;
      have_r    <= have_nxt;
      done_r    <= done_nxt;
      star_v_r  <= star_v_nxt;
      prime_v_r <= prime_v_nxt;
      row_cov_r <= row_cov_nxt;
      col_cov_r <= col_cov_nxt;
      asg_v_r   <= asg_v_nxt;
      old_v_r   <= old_v_nxt;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    star_col_r  <= star_col_nxt;
    prime_col_r <= prime_col_nxt;
    old_col_r   <= old_col_nxt;
    max_r       <= max_nxt;
    min_r       <= min_nxt;
    sc_r        <= sc_nxt;
    pr_r        <= pr_nxt;
    pc_r        <= pc_nxt;
    nprod_r     <= nprod_nxt;
    prod_r      <= prod_nxt;
    infv_r      <= infv_nxt;
    total_r     <= total_nxt;
  end

  // Ports.
  assign in_ready           = (state_r == S_LOAD);
  assign out_valid          = (state_r == S_OUT);
  assign out_row_index      = IW'(b_r);
  assign out_assigned_col   = asg_v_r[b_r] ? IW'(star_col_r[b_r]) : '0;
  assign out_assigned_valid = asg_v_r[b_r];
  assign out_total_cost     = total_r;
  assign out_last_row       = (b_r == rows_m1);

  // Loading and reporting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result channels active together");

  // A reported column lies inside the configured matrix.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_assigned_valid |-> (DW'(star_col_r[b_r]) < cols_r))
    else $error("assigned column out of range");

  // The block is ready for a new matrix right after the last result.
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_row && !cfg_we |=> in_ready)
    else $error("no return to loading after the last result");

endmodule
